// File: sv/ftpr_pkg.sv
// Shared types and constants of the FTP reply framer.
package ftpr_pkg;

	localparam int unsigned CODE_W = 10;
	localparam int unsigned LEN_W  = 21;
	localparam int unsigned ERR_W  = 2;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned POS_W  = 3;

	localparam logic [LEN_W-1:0] MAX_REPLY_RESET = LEN_W'(65536);

	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
	localparam logic [3:0]        DIGIT_HI = 4'h3;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_CLOSED = 1'b1;

	localparam logic [POS_W-1:0] POS_CR   = 3'd0;
	localparam logic [POS_W-1:0] POS_LF   = 3'd1;
	localparam logic [POS_W-1:0] POS_D0   = 3'd2;
	localparam logic [POS_W-1:0] POS_D1   = 3'd3;
	localparam logic [POS_W-1:0] POS_D2   = 3'd4;
	localparam logic [POS_W-1:0] POS_SP   = 3'd5;
	localparam logic [POS_W-1:0] POS_DONE = 3'd6;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE      = 2'd0,
		ERR_MALFORMED = 2'd1,
		ERR_TOO_LONG  = 2'd2,
		ERR_CLOSED    = 2'd3
	} err_t;

	typedef enum logic [7:0] {
		PH_D0     = 8'b0000_0001,
		PH_D1     = 8'b0000_0010,
		PH_D2     = 8'b0000_0100,
		PH_SEP    = 8'b0000_1000,
		PH_SINGLE = 8'b0001_0000,
		PH_NEEDLE = 8'b0010_0000,
		PH_FINAL  = 8'b0100_0000,
		PH_BAD    = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [CODE_W-1:0] status_code;
		logic [LEN_W-1:0]  reply_length;
		logic              multi_line;
		err_t              error;
	} result_t;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] rx_byte;
	} item_t;

endpackage

// File: sv/ftpr_in_stage.sv
// Input register of the FTP reply framer.
module ftpr_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  ftpr_pkg::item_t in_item,
	input  logic            advance,
	output logic            item_valid,
	output ftpr_pkg::item_t item
);

	logic            valid_s1;
	ftpr_pkg::item_t item_s1;
	logic            take;

	assign in_stall   = valid_s1 && !advance;
	assign take       = in_valid && !in_stall;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= in_item;
		end
	end

endmodule

// File: sv/ftpr_framer.sv
// Reply framing state and per-byte decision logic.
module ftpr_framer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  ftpr_pkg::item_t               item,
	input  logic [ftpr_pkg::LEN_W-1:0]    max_reply_bytes,
	output logic                          res_valid,
	output ftpr_pkg::result_t             res
);

	ftpr_pkg::phase_t               phase_q, phase_d;
	logic [ftpr_pkg::CODE_W-1:0]    code_q, code_d;
	logic [3:0]                     dig_q [3];
	logic [3:0]                     dig_d [3];
	logic                           multi_q, multi_d;
	logic [ftpr_pkg::LEN_W-1:0]     count_q, count_d;
	logic [ftpr_pkg::POS_W-1:0]     pos_q, pos_d;
	logic                           cr_q, cr_d;

	logic [ftpr_pkg::LEN_W:0]       count_inc;
	logic [ftpr_pkg::CODE_W+3:0]    code_mul;
	logic [ftpr_pkg::BYTE_W-1:0]    b;
	logic [ftpr_pkg::BYTE_W-1:0]    want;
	logic                           is_digit;
	logic                           restart;
	logic [ftpr_pkg::POS_W-1:0]     pos_inc;

	assign b         = item.rx_byte;
	assign is_digit  = (b >= ftpr_pkg::CH_ZERO) && (b <= ftpr_pkg::CH_NINE);
	assign count_inc = {1'b0, count_q} + (ftpr_pkg::LEN_W+1)'(1);
	assign code_mul  = ({4'b0, code_q} << 3) + ({4'b0, code_q} << 1)
		+ (ftpr_pkg::CODE_W+4)'(b[3:0]);
	assign pos_inc   = pos_q + ftpr_pkg::POS_W'(1);

	always_comb begin
		case (pos_q)
			ftpr_pkg::POS_CR: want = ftpr_pkg::CH_CR;
			ftpr_pkg::POS_LF: want = ftpr_pkg::CH_LF;
			ftpr_pkg::POS_D0: want = {ftpr_pkg::DIGIT_HI, dig_q[0]};
			ftpr_pkg::POS_D1: want = {ftpr_pkg::DIGIT_HI, dig_q[1]};
			ftpr_pkg::POS_D2: want = {ftpr_pkg::DIGIT_HI, dig_q[2]};
			default:          want = ftpr_pkg::CH_SPACE;
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		code_d    = code_q;
		dig_d     = dig_q;
		multi_d   = multi_q;
		count_d   = count_q;
		pos_d     = pos_q;
		cr_d      = cr_q;
		res_valid = 1'b0;
		restart   = 1'b0;
		res       = '{status_code: '0, reply_length: '0, multi_line: 1'b0,
			error: ftpr_pkg::ERR_NONE};

		if (item.kind == ftpr_pkg::KIND_CLOSED) begin
			res_valid = 1'b1;
			res.error = ftpr_pkg::ERR_CLOSED;
		end else if (count_inc > {1'b0, max_reply_bytes}) begin
			res_valid = 1'b1;
			res.error = ftpr_pkg::ERR_TOO_LONG;
		end else begin
			count_d = count_inc[ftpr_pkg::LEN_W-1:0];
			case (phase_q)
				ftpr_pkg::PH_D0, ftpr_pkg::PH_D1, ftpr_pkg::PH_D2: begin
					if (is_digit) begin
						code_d = ftpr_pkg::CODE_W'(code_mul);
						if (phase_q == ftpr_pkg::PH_D0) begin
							dig_d[0] = b[3:0];
							phase_d  = ftpr_pkg::PH_D1;
						end else if (phase_q == ftpr_pkg::PH_D1) begin
							dig_d[1] = b[3:0];
							phase_d  = ftpr_pkg::PH_D2;
						end else begin
							dig_d[2] = b[3:0];
							phase_d  = ftpr_pkg::PH_SEP;
						end
					end else begin
						phase_d = ftpr_pkg::PH_BAD;
					end
				end
				ftpr_pkg::PH_SEP: begin
					if (code_q == '0
						|| (b != ftpr_pkg::CH_SPACE && b != ftpr_pkg::CH_DASH)) begin
						res_valid = 1'b1;
						res.error = ftpr_pkg::ERR_MALFORMED;
					end else begin
						if (b == ftpr_pkg::CH_DASH) begin
							multi_d = 1'b1;
							phase_d = ftpr_pkg::PH_NEEDLE;
						end else begin
							phase_d = ftpr_pkg::PH_SINGLE;
						end
						pos_d = ftpr_pkg::POS_CR;
						cr_d  = 1'b0;
					end
				end
				ftpr_pkg::PH_SINGLE, ftpr_pkg::PH_FINAL: begin
					if (cr_q && b == ftpr_pkg::CH_LF) begin
						res_valid = 1'b1;
						res = '{status_code: code_q,
							reply_length: count_inc[ftpr_pkg::LEN_W-1:0],
							multi_line: multi_q, error: ftpr_pkg::ERR_NONE};
					end else begin
						cr_d = (b == ftpr_pkg::CH_CR);
					end
				end
				ftpr_pkg::PH_NEEDLE: begin
					if (b == want) begin
						if (pos_inc == ftpr_pkg::POS_DONE) begin
							phase_d = ftpr_pkg::PH_FINAL;
							pos_d   = ftpr_pkg::POS_CR;
							cr_d    = 1'b0;
						end else begin
							pos_d = pos_inc;
						end
					end else begin
						pos_d = (b == ftpr_pkg::CH_CR) ? ftpr_pkg::POS_LF
							: ftpr_pkg::POS_CR;
					end
				end
				default: begin
					if (count_inc >= (ftpr_pkg::LEN_W+1)'(4)) begin
						res_valid = 1'b1;
						res.error = ftpr_pkg::ERR_MALFORMED;
					end
				end
			endcase
		end
		restart = res_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ftpr_pkg::PH_D0;
			code_q  <= '0;
			multi_q <= 1'b0;
			count_q <= '0;
			pos_q   <= ftpr_pkg::POS_CR;
			cr_q    <= 1'b0;
		end else if (fire) begin
			if (restart) begin
				phase_q <= ftpr_pkg::PH_D0;
				code_q  <= '0;
				multi_q <= 1'b0;
				count_q <= '0;
				pos_q   <= ftpr_pkg::POS_CR;
				cr_q    <= 1'b0;
			end else begin
				phase_q <= phase_d;
				code_q  <= code_d;
				multi_q <= multi_d;
				count_q <= count_d;
				pos_q   <= pos_d;
				cr_q    <= cr_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			dig_q <= dig_d;
		end
	end

endmodule

// File: sv/ftpr_out_stage.sv
// Result register of the FTP reply framer.
module ftpr_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  ftpr_pkg::result_t res,
	output logic              free,
	output logic              out_valid,
	input  logic              out_stall,
	output ftpr_pkg::result_t out_res
);

	logic              valid_s2;
	ftpr_pkg::result_t res_s2;

	assign free      = !valid_s2 || !out_stall;
	assign out_valid = valid_s2;
	assign out_res   = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

endmodule

// File: sv/ftp_reply_framer_core.sv
// Top level of the FTP reply framer.
//
// Input channel: in_valid/in_stall carry one control-channel event per transfer:
// kind 0 is a received byte in rx_byte, kind 1 reports that the peer closed.
// Output channel: out_valid/out_stall carry one framed reply per transfer:
// status_code, reply_length (including the final CR LF), multi_line and error
// (0 ok, 1 malformed status line, 2 reply too long, 3 stream closed).
// Configuration: cfg_valid/cfg_ready write max_reply_bytes; cfg_ready is always
// high. Write only while no event is in flight.
// Path: an event is captured in the input register, passes the framing logic and
// its result, if any, is captured in the result register, which drives out_valid.
// Throughput: one event per cycle while no held result stalls the input, set by
// the single pass of framing logic between the input register and the result register.
// Reset: framing restarts at the first status digit, max_reply_bytes returns
// to 65536 and both registers are emptied.
// Stall: a held result keeps the next result-producing event in the input
// register, which raises in_stall; events that produce no result keep flowing.
module ftp_reply_framer_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           kind,
	input  logic [ftpr_pkg::BYTE_W-1:0]    rx_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ftpr_pkg::CODE_W-1:0]    status_code,
	output logic [ftpr_pkg::LEN_W-1:0]     reply_length,
	output logic                           multi_line,
	output logic [ftpr_pkg::ERR_W-1:0]     error,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ftpr_pkg::LEN_W-1:0]     max_reply_bytes
);

	logic [ftpr_pkg::LEN_W-1:0] max_q;
	ftpr_pkg::item_t            in_item;
	ftpr_pkg::item_t            item;
	logic                       item_valid;
	logic                       advance;
	logic                       fire;
	logic                       res_valid;
	logic                       free;
	ftpr_pkg::result_t          res;
	ftpr_pkg::result_t          out_res;

	assign cfg_ready = 1'b1;
	assign in_item   = '{kind: kind, rx_byte: rx_byte};
	assign advance   = item_valid && (!res_valid || free);
	assign fire      = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= ftpr_pkg::MAX_REPLY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_q <= max_reply_bytes;
		end
	end

	ftpr_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	ftpr_framer u_framer (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.item            (item),
		.max_reply_bytes (max_q),
		.res_valid       (res_valid),
		.res             (res)
	);

	ftpr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && res_valid),
		.res       (res),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign status_code  = out_res.status_code;
	assign reply_length = out_res.reply_length;
	assign multi_line   = out_res.multi_line;
	assign error        = out_res.error;

endmodule

// File: test/ftpr_reply_checker.sv
// Reply checker for the FTP reply framer: predicts framed replies and compares them.
`timescale 1ns / 100ps

module ftpr_reply_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic                        kind,
	input  logic [ftpr_pkg::BYTE_W-1:0] rx_byte,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [ftpr_pkg::CODE_W-1:0] status_code,
	input  logic [ftpr_pkg::LEN_W-1:0]  reply_length,
	input  logic                        multi_line,
	input  logic [ftpr_pkg::ERR_W-1:0]  error,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [ftpr_pkg::LEN_W-1:0]  max_reply_bytes,
	output int unsigned                 fail_count,
	output int unsigned                 pending
);
	import ftpr_pkg::*;

	phase_t             ph;
	logic [CODE_W-1:0]  code_acc;
	logic               multi;
	logic [LEN_W-1:0]   bytes_seen;
	logic [POS_W-1:0]   match_at;
	logic               last_cr;
	logic [LEN_W-1:0]   reply_limit;
	result_t            expected_replies[$];

	function automatic void restart_frame();
		ph = PH_D0;
		code_acc = '0;
		multi = 1'b0;
		bytes_seen = '0;
		match_at = POS_CR;
		last_cr = 1'b0;
	endfunction

	function automatic bit frame_byte(input logic k, input logic [BYTE_W-1:0] b,
			output result_t res);
		logic [LEN_W:0]    next_count;
		logic [BYTE_W-1:0] want;
		bit                done;
		res = '0;
		done = 1'b0;
		if (k == KIND_CLOSED) begin
			res.error = ERR_CLOSED;
			done = 1'b1;
		end else begin
			next_count = {1'b0, bytes_seen} + 1'b1;
			if (next_count > {1'b0, reply_limit}) begin
				res.error = ERR_TOO_LONG;
				done = 1'b1;
			end else begin
				bytes_seen = next_count[LEN_W-1:0];
				case (ph)
					PH_D0, PH_D1, PH_D2: begin
						if (b >= CH_ZERO && b <= CH_NINE) begin
							code_acc = CODE_W'(code_acc * 10 + (b - CH_ZERO));
							if (ph == PH_D0)
								ph = PH_D1;
							else if (ph == PH_D1)
								ph = PH_D2;
							else
								ph = PH_SEP;
						end else begin
							ph = PH_BAD;
						end
					end
					PH_SEP: begin
						if (code_acc == '0 || (b != CH_SPACE && b != CH_DASH)) begin
							res.error = ERR_MALFORMED;
							done = 1'b1;
						end else begin
							if (b == CH_DASH) begin
								multi = 1'b1;
								ph = PH_NEEDLE;
							end else begin
								ph = PH_SINGLE;
							end
							match_at = POS_CR;
							last_cr = 1'b0;
						end
					end
					PH_SINGLE, PH_FINAL: begin
						if (last_cr && b == CH_LF) begin
							res.status_code = code_acc;
							res.reply_length = bytes_seen;
							res.multi_line = multi;
							res.error = ERR_NONE;
							done = 1'b1;
						end else begin
							last_cr = (b == CH_CR);
						end
					end
					PH_NEEDLE: begin
						case (match_at)
							POS_CR: want = CH_CR;
							POS_LF: want = CH_LF;
							POS_D0: want = CH_ZERO + BYTE_W'(code_acc / 100);
							POS_D1: want = CH_ZERO + BYTE_W'((code_acc / 10) % 10);
							POS_D2: want = CH_ZERO + BYTE_W'(code_acc % 10);
							default: want = CH_SPACE;
						endcase
						if (b == want) begin
							match_at = match_at + 1'b1;
							if (match_at == POS_DONE) begin
								ph = PH_FINAL;
								match_at = POS_CR;
								last_cr = 1'b0;
							end
						end else begin
							match_at = (b == CH_CR) ? POS_LF : POS_CR;
						end
					end
					default: begin
						if (bytes_seen >= LEN_W'(4)) begin
							res.error = ERR_MALFORMED;
							done = 1'b1;
						end
					end
				endcase
			end
		end
		if (done)
			restart_frame();
		return done;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t oldest;
		result_t predicted;
		if (!arst_n) begin
			restart_frame();
			reply_limit = MAX_REPLY_RESET;
			expected_replies.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid === 1'b1 && out_stall == 1'b0) begin
				if (expected_replies.size() == 0) begin
					$error("unexpected reply: status_code %0d, reply_length %0d, error %0d",
						status_code, reply_length, error);
					fail_count++;
				end else begin
					oldest = expected_replies.pop_front();
					if (status_code !== oldest.status_code) begin
						$error("status_code: expected %0d, got %0d", oldest.status_code,
							status_code);
						fail_count++;
					end
					if (reply_length !== oldest.reply_length) begin
						$error("reply_length: expected %0d, got %0d", oldest.reply_length,
							reply_length);
						fail_count++;
					end
					if (multi_line !== oldest.multi_line) begin
						$error("multi_line: expected %0d, got %0d", oldest.multi_line,
							multi_line);
						fail_count++;
					end
					if (error !== oldest.error) begin
						$error("error: expected %0d, got %0d", oldest.error, error);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				reply_limit = max_reply_bytes;
			if (in_valid && !in_stall) begin
				if (frame_byte(kind, rx_byte, predicted))
					expected_replies.push_back(predicted);
			end
			pending = expected_replies.size();
		end
	end

endmodule

// File: test/tb_ftp_reply_framer_core.sv
// Testbench top for the FTP reply framer core: byte stream stimulus, limit changes and verdict.
`timescale 1ns / 100ps

module tb_ftp_reply_framer_core;
	import ftpr_pkg::*;

	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned QUIET_LIMIT   = 2000;
	localparam int unsigned PHASE_ITEMS   = 185;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               kind = KIND_DATA;
	logic [BYTE_W-1:0]  rx_byte = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [CODE_W-1:0]  status_code;
	logic [LEN_W-1:0]   reply_length;
	logic               multi_line;
	logic [ERR_W-1:0]   error;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [LEN_W-1:0]   max_reply_bytes = MAX_REPLY_RESET;
	int unsigned        fail_count;
	int unsigned        pending;

	int unsigned        src_idle_pct = 21;
	int unsigned        snk_idle_pct = 63;
	int unsigned        sent_count = 0;
	int unsigned        quiet_cycles = 0;
	item_t              tx_q[$];

	ftp_reply_framer_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status_code    (status_code),
		.reply_length   (reply_length),
		.multi_line     (multi_line),
		.error          (error),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.max_reply_bytes(max_reply_bytes)
	);

	ftpr_reply_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status_code    (status_code),
		.reply_length   (reply_length),
		.multi_line     (multi_line),
		.error          (error),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.max_reply_bytes(max_reply_bytes),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < snk_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic void push_event(logic k, logic [BYTE_W-1:0] b);
		item_t it;
		it.kind = k;
		it.rx_byte = b;
		tx_q.push_back(it);
	endfunction

	function automatic void push_code(int unsigned c);
		push_event(KIND_DATA, CH_ZERO + BYTE_W'(c / 100));
		push_event(KIND_DATA, CH_ZERO + BYTE_W'((c / 10) % 10));
		push_event(KIND_DATA, CH_ZERO + BYTE_W'(c % 10));
	endfunction

	function automatic void push_crlf();
		push_event(KIND_DATA, CH_CR);
		push_event(KIND_DATA, CH_LF);
	endfunction

	function automatic void push_text(int unsigned n);
		int unsigned r;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 85)
				push_event(KIND_DATA, BYTE_W'($urandom_range(8'h7E, 8'h20)));
			else if (r < 95)
				push_event(KIND_DATA, CH_CR);
			else
				push_event(KIND_DATA, BYTE_W'($urandom_range(255)));
		end
	endfunction

	task automatic send_queue();
		item_t it;
		while (tx_q.size() != 0) begin
			it = tx_q.pop_front();
			while ($urandom_range(99) < src_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			kind <= it.kind;
			rx_byte <= it.rx_byte;
			do
				@(posedge clk);
			while (!(in_valid && !in_stall));
			sent_count++;
		end
	endtask

	task automatic wait_for_quiet();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [LEN_W-1:0] limit_plan [6];
		int unsigned      pick;
		int unsigned      code;
		int unsigned      cut;
		limit_plan[0] = LEN_W'(1048576);
		limit_plan[1] = LEN_W'(6);
		limit_plan[2] = LEN_W'($urandom_range(48, 7));
		limit_plan[3] = LEN_W'(1048575);
		limit_plan[4] = LEN_W'($urandom_range(400, 49));
		limit_plan[5] = MAX_REPLY_RESET;

		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		push_code(200);
		push_event(KIND_DATA, CH_SPACE);
		push_crlf();
		push_event(KIND_DATA, CH_ZERO);
		push_event(KIND_DATA, CH_ZERO + 8'd5);
		push_event(KIND_CLOSED, 8'hFF);
		push_event(KIND_CLOSED, 8'h00);
		push_code(0);
		push_event(KIND_DATA, CH_SPACE);
		push_event(KIND_DATA, 8'hFF);
		push_event(KIND_DATA, 8'h00);
		push_event(KIND_DATA, CH_NINE);
		push_event(KIND_DATA, CH_DASH);
		push_code(123);
		push_event(KIND_DATA, "x");
		send_queue();
		wait_for_quiet();

		for (int p = 0; p < 6; p++) begin
			if (p < 2) begin
				src_idle_pct = 21;
				snk_idle_pct = 63;
			end else if (p < 4) begin
				src_idle_pct = 63;
				snk_idle_pct = 21;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end

			cfg_valid <= 1'b1;
			max_reply_bytes <= limit_plan[p];
			do
				@(posedge clk);
			while (!cfg_ready);
			cfg_valid <= 1'b0;

			sent_count = 0;
			while (sent_count < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				code = ($urandom_range(3) == 0) ? $urandom_range(99) : $urandom_range(999);
				if (pick < 40) begin
					push_code(code);
					push_event(KIND_DATA, CH_SPACE);
					push_text($urandom_range(10));
					push_crlf();
				end else if (pick < 75) begin
					push_code(code);
					push_event(KIND_DATA, CH_DASH);
					push_text($urandom_range(10));
					push_crlf();
					repeat ($urandom_range(3)) begin
						case ($urandom_range(3))
							0: push_text($urandom_range(10));
							1: begin
								push_code(code);
								push_event(KIND_DATA, CH_DASH);
								push_text($urandom_range(6));
							end
							2: begin
								push_code((code + 1 + $urandom_range(998)) % 1000);
								push_event(KIND_DATA, CH_SPACE);
								push_text($urandom_range(6));
							end
							default: begin
								push_code(code);
								push_text($urandom_range(3));
							end
						endcase
						push_crlf();
					end
					push_code(code);
					push_event(KIND_DATA, CH_SPACE);
					push_text($urandom_range(10));
					push_crlf();
				end else if (pick < 85) begin
					cut = $urandom_range(5);
					if (cut < 3) begin
						repeat (cut) push_event(KIND_DATA, CH_ZERO + BYTE_W'($urandom_range(9)));
					end else begin
						push_code(code);
						push_event(KIND_DATA, ($urandom_range(1) != 0) ? CH_DASH : CH_SPACE);
						push_text($urandom_range(8));
						if (cut == 5)
							push_crlf();
					end
					push_event(KIND_CLOSED, BYTE_W'($urandom_range(255)));
				end else if (pick < 93) begin
					repeat (3) begin
						if ($urandom_range(3) == 0)
							push_event(KIND_DATA, BYTE_W'($urandom_range(255)));
						else
							push_event(KIND_DATA, CH_ZERO + BYTE_W'($urandom_range(9)));
					end
					if ($urandom_range(1) != 0)
						push_event(KIND_DATA, BYTE_W'($urandom_range(255)));
					else
						push_event(KIND_DATA, ($urandom_range(1) != 0) ? CH_DASH : CH_SPACE);
				end else begin
					repeat ($urandom_range(8, 1))
						push_event(KIND_DATA, BYTE_W'($urandom_range(255)));
					if ($urandom_range(1) != 0)
						push_event(KIND_CLOSED, BYTE_W'($urandom_range(255)));
				end
				send_queue();
			end
			wait_for_quiet();
		end

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
